@@ rtl/bpc_pkg.sv @@
// Shared types, widths and constants for the barometric compensation block.
// Used by every module of the block; depends on nothing.
package bpc_pkg;

  localparam int IN_W    = 24;
  localparam int CAL_W   = 16;
  localparam int IDX_W   = 3;
  localparam int DT_W    = 25;
  localparam int MUL_W   = 42;
  localparam int DSQ_W   = 48;
  localparam int DSQF_W  = 50;
  localparam int T2_W    = 17;
  localparam int TEMP_W  = 19;
  localparam int OFF_W   = 35;
  localparam int SENS_W  = 34;
  localparam int SQT_W   = 36;
  localparam int SQX_W   = 40;
  localparam int FIN_W   = 41;
  localparam int LO_W    = 20;
  localparam int PL_W    = 44;
  localparam int PH_W    = 46;
  localparam int PROD_W  = 66;
  localparam int DIFF_W  = 46;
  localparam int PQ_W    = 31;
  localparam int PRESS_W = 27;

  localparam int C5_SHIFT         = 8;
  localparam int TEMP_SHIFT       = 23;
  localparam int OFF_BASE_SHIFT   = 16;
  localparam int SENS_BASE_SHIFT  = 15;
  localparam int OFF_TC_SHIFT     = 7;
  localparam int SENS_TC_SHIFT    = 8;
  localparam int T2_SHIFT         = 31;
  localparam int SENS_APPLY_SHIFT = 21;
  localparam int P_FINAL_SHIFT    = 15;

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;
  localparam int P_MAX     = 67108863;
  localparam int P_MIN     = -67108864;

  typedef enum logic [IDX_W-1:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_SLOPE      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_slope;
  } cal_t;

  typedef struct packed {
    logic [IN_W-1:0]   d1;
    logic [TEMP_W-1:0] temp;
    logic [OFF_W-1:0]  off;
    logic [SENS_W-1:0] sens;
    logic [T2_W-1:0]   t2;
  } scale_t;

  typedef struct packed {
    logic [IN_W-1:0]   d1;
    logic [FIN_W-1:0]  off_f;
    logic [FIN_W-1:0]  sens_f;
    logic [TEMP_W-1:0] temp_out;
  } corr_t;

endpackage

@@ rtl/bpc_scale.sv @@
// First three pipeline stages: dT, the four dT products, and first-order scaling.
// Depends on bpc_pkg.
module bpc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_in,
  input  logic [bpc_pkg::IN_W-1:0]    raw_pressure,
  input  logic [bpc_pkg::IN_W-1:0]    raw_temperature,
  input  bpc_pkg::cal_t               cal,
  output logic                        valid_out,
  output bpc_pkg::scale_t             data_out
);

  logic                              s1_valid;
  logic [bpc_pkg::IN_W-1:0]          s1_d1;
  logic signed [bpc_pkg::DT_W-1:0]   s1_dt;
  logic signed [bpc_pkg::DT_W-1:0]   s1_dt_next;

  logic                              s2_valid;
  logic [bpc_pkg::IN_W-1:0]          s2_d1;
  logic signed [bpc_pkg::MUL_W-1:0]  s2_p_temp;
  logic signed [bpc_pkg::MUL_W-1:0]  s2_p_off;
  logic signed [bpc_pkg::MUL_W-1:0]  s2_p_sens;
  logic [bpc_pkg::DSQ_W-1:0]         s2_dt_sq;
  logic signed [bpc_pkg::MUL_W-1:0]  p_temp_next;
  logic signed [bpc_pkg::MUL_W-1:0]  p_off_next;
  logic signed [bpc_pkg::MUL_W-1:0]  p_sens_next;
  logic signed [bpc_pkg::DSQF_W-1:0] dt_sq_full;

  logic signed [bpc_pkg::MUL_W-1:0]  temp_q;
  logic signed [bpc_pkg::MUL_W-1:0]  off_q;
  logic signed [bpc_pkg::MUL_W-1:0]  sens_q;
  logic signed [bpc_pkg::MUL_W-1:0]  temp_sum;
  logic signed [bpc_pkg::MUL_W-1:0]  off_sum;
  logic signed [bpc_pkg::MUL_W-1:0]  sens_sum;

  assign s1_dt_next = bpc_pkg::DT_W'(
    $signed({2'b00, raw_temperature}) -
    $signed({2'b00, cal.reference_temperature, {bpc_pkg::C5_SHIFT{1'b0}}}));

  always_comb begin
    p_temp_next = s1_dt * $signed({1'b0, cal.temperature_slope});
    p_off_next  = s1_dt * $signed({1'b0, cal.offset_temp_coeff});
    p_sens_next = s1_dt * $signed({1'b0, cal.sensitivity_temp_coeff});
    dt_sq_full  = s1_dt * s1_dt;
  end

  // round toward zero: add 2^k-1 to negative values before the shift
  always_comb begin
    temp_q = (s2_p_temp + $signed({{(bpc_pkg::MUL_W-bpc_pkg::TEMP_SHIFT){1'b0}},
              {bpc_pkg::TEMP_SHIFT{s2_p_temp[bpc_pkg::MUL_W-1]}}})) >>> bpc_pkg::TEMP_SHIFT;
    off_q  = (s2_p_off + $signed({{(bpc_pkg::MUL_W-bpc_pkg::OFF_TC_SHIFT){1'b0}},
              {bpc_pkg::OFF_TC_SHIFT{s2_p_off[bpc_pkg::MUL_W-1]}}})) >>> bpc_pkg::OFF_TC_SHIFT;
    sens_q = (s2_p_sens + $signed({{(bpc_pkg::MUL_W-bpc_pkg::SENS_TC_SHIFT){1'b0}},
              {bpc_pkg::SENS_TC_SHIFT{s2_p_sens[bpc_pkg::MUL_W-1]}}})) >>> bpc_pkg::SENS_TC_SHIFT;
    temp_sum = temp_q + bpc_pkg::MUL_W'(bpc_pkg::TEMP_REF);
    off_sum  = off_q + $signed({1'b0, cal.pressure_offset,
                                {bpc_pkg::OFF_BASE_SHIFT{1'b0}}});
    sens_sum = sens_q + $signed({1'b0, cal.pressure_sensitivity,
                                 {bpc_pkg::SENS_BASE_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      s1_valid  <= valid_in;
      s2_valid  <= s1_valid;
      valid_out <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1         <= raw_pressure;
      s1_dt         <= s1_dt_next;
      s2_d1         <= s1_d1;
      s2_p_temp     <= p_temp_next;
      s2_p_off      <= p_off_next;
      s2_p_sens     <= p_sens_next;
      s2_dt_sq      <= dt_sq_full[bpc_pkg::DSQ_W-1:0];
      data_out.d1   <= s2_d1;
      data_out.temp <= temp_sum[bpc_pkg::TEMP_W-1:0];
      data_out.off  <= off_sum[bpc_pkg::OFF_W-1:0];
      data_out.sens <= sens_sum[bpc_pkg::SENS_W-1:0];
      data_out.t2   <= s2_dt_sq[bpc_pkg::DSQ_W-1:bpc_pkg::T2_SHIFT];
    end
  end

endmodule

@@ rtl/bpc_corr.sv @@
// Stages four and five: second-order correction terms and corrected OFF, SENS, TEMP.
// Depends on bpc_pkg.
module bpc_corr (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  bpc_pkg::scale_t data_in,
  output logic            valid_out,
  output bpc_pkg::corr_t  data_out
);

  logic signed [bpc_pkg::TEMP_W-1:0]   temp_in;
  logic signed [bpc_pkg::TEMP_W:0]     dw;
  logic signed [bpc_pkg::TEMP_W:0]     dc;
  logic signed [2*bpc_pkg::TEMP_W+1:0] dw_sq;
  logic signed [2*bpc_pkg::TEMP_W+1:0] dc_sq;

  logic                        s4_valid;
  logic [bpc_pkg::IN_W-1:0]    s4_d1;
  logic [bpc_pkg::TEMP_W-1:0]  s4_temp;
  logic [bpc_pkg::OFF_W-1:0]   s4_off;
  logic [bpc_pkg::SENS_W-1:0]  s4_sens;
  logic [bpc_pkg::T2_W-1:0]    s4_t2;
  logic [bpc_pkg::SQT_W-1:0]   s4_sqw;
  logic [bpc_pkg::SQT_W-1:0]   s4_sqc;
  logic                        s4_warm;
  logic                        s4_cold;

  logic [bpc_pkg::SQX_W-1:0]   w5;
  logic [bpc_pkg::SQX_W-1:0]   c7;
  logic [bpc_pkg::SQX_W-1:0]   c11;
  logic [bpc_pkg::SQX_W-1:0]   off2;
  logic [bpc_pkg::SQX_W-1:0]   sens2;
  logic signed [bpc_pkg::FIN_W-1:0] off_f_next;
  logic signed [bpc_pkg::FIN_W-1:0] sens_f_next;
  logic signed [bpc_pkg::TEMP_W:0]  temp_out_next;

  always_comb begin
    temp_in = $signed(data_in.temp);
    dw      = (bpc_pkg::TEMP_W+1)'(temp_in) - (bpc_pkg::TEMP_W+1)'(bpc_pkg::TEMP_REF);
    dc      = (bpc_pkg::TEMP_W+1)'(temp_in) - (bpc_pkg::TEMP_W+1)'(bpc_pkg::TEMP_COLD);
    dw_sq   = dw * dw;
    dc_sq   = dc * dc;
  end

  always_comb begin
    w5    = {{(bpc_pkg::SQX_W-bpc_pkg::SQT_W-2){1'b0}}, s4_sqw, 2'b00}
          + bpc_pkg::SQX_W'(s4_sqw);
    c7    = {{(bpc_pkg::SQX_W-bpc_pkg::SQT_W-3){1'b0}}, s4_sqc, 3'b000}
          - bpc_pkg::SQX_W'(s4_sqc);
    c11   = {{(bpc_pkg::SQX_W-bpc_pkg::SQT_W-3){1'b0}}, s4_sqc, 3'b000}
          + {{(bpc_pkg::SQX_W-bpc_pkg::SQT_W-1){1'b0}}, s4_sqc, 1'b0}
          + bpc_pkg::SQX_W'(s4_sqc);
    off2  = (s4_warm ? (w5 >> 1) : '0) + (s4_cold ? c7 : '0);
    sens2 = (s4_warm ? (w5 >> 2) : '0) + (s4_cold ? (c11 >> 1) : '0);
    off_f_next    = bpc_pkg::FIN_W'($signed(s4_off)) - $signed({1'b0, off2});
    sens_f_next   = bpc_pkg::FIN_W'($signed(s4_sens)) - $signed({1'b0, sens2});
    temp_out_next = (bpc_pkg::TEMP_W+1)'($signed(s4_temp))
                  - $signed({3'b000, (s4_warm ? s4_t2 : {bpc_pkg::T2_W{1'b0}})});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      s4_valid  <= valid_in;
      valid_out <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_d1             <= data_in.d1;
      s4_temp           <= data_in.temp;
      s4_off            <= data_in.off;
      s4_sens           <= data_in.sens;
      s4_t2             <= data_in.t2;
      s4_sqw            <= dw_sq[bpc_pkg::SQT_W-1:0];
      s4_sqc            <= dc_sq[bpc_pkg::SQT_W-1:0];
      s4_warm           <= temp_in < bpc_pkg::TEMP_W'(bpc_pkg::TEMP_REF);
      s4_cold           <= temp_in < bpc_pkg::TEMP_W'(bpc_pkg::TEMP_COLD);
      data_out.d1       <= s4_d1;
      data_out.off_f    <= off_f_next;
      data_out.sens_f   <= sens_f_next;
      data_out.temp_out <= temp_out_next[bpc_pkg::TEMP_W-1:0];
    end
  end

endmodule

@@ rtl/bpc_press.sv @@
// Stages six to nine: split D1*SENS product, final scaling, saturation, output register.
// Depends on bpc_pkg.
module bpc_press (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                valid_in,
  input  bpc_pkg::corr_t                      data_in,
  output logic                                valid_out,
  output logic signed [bpc_pkg::PRESS_W-1:0]  pressure_pa,
  output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_centi
);

  logic                               s6_valid;
  logic [bpc_pkg::PL_W-1:0]           s6_pl;
  logic signed [bpc_pkg::PH_W-1:0]    s6_ph;
  logic [bpc_pkg::FIN_W-1:0]          s6_off_f;
  logic [bpc_pkg::TEMP_W-1:0]         s6_temp;
  logic [bpc_pkg::PL_W-1:0]           pl_next;
  logic signed [bpc_pkg::PH_W-1:0]    ph_next;

  logic                               s7_valid;
  logic signed [bpc_pkg::PROD_W-1:0]  s7_prod;
  logic [bpc_pkg::FIN_W-1:0]          s7_off_f;
  logic [bpc_pkg::TEMP_W-1:0]         s7_temp;
  logic signed [bpc_pkg::PROD_W-1:0]  prod_next;

  logic                               s8_valid;
  logic signed [bpc_pkg::DIFF_W-1:0]  s8_diff;
  logic [bpc_pkg::TEMP_W-1:0]         s8_temp;
  logic signed [bpc_pkg::PROD_W-1:0]  prod_q;
  logic signed [bpc_pkg::DIFF_W-1:0]  diff_next;

  logic signed [bpc_pkg::DIFF_W-1:0]  p_q;
  logic signed [bpc_pkg::PQ_W-1:0]    p_w;
  logic signed [bpc_pkg::PRESS_W-1:0] p_sat;

  always_comb begin
    pl_next = data_in.d1 * data_in.sens_f[bpc_pkg::LO_W-1:0];
    ph_next = $signed({1'b0, data_in.d1})
            * $signed(data_in.sens_f[bpc_pkg::FIN_W-1:bpc_pkg::LO_W]);
    prod_next = $signed({s6_ph, {bpc_pkg::LO_W{1'b0}}})
              + $signed({{(bpc_pkg::PROD_W-bpc_pkg::PL_W){1'b0}}, s6_pl});
  end

  // round toward zero before each shift
  always_comb begin
    prod_q = (s7_prod + $signed({{(bpc_pkg::PROD_W-bpc_pkg::SENS_APPLY_SHIFT){1'b0}},
              {bpc_pkg::SENS_APPLY_SHIFT{s7_prod[bpc_pkg::PROD_W-1]}}}))
             >>> bpc_pkg::SENS_APPLY_SHIFT;
    diff_next = prod_q[bpc_pkg::DIFF_W-1:0]
              - bpc_pkg::DIFF_W'($signed(s7_off_f));
    p_q = (s8_diff + $signed({{(bpc_pkg::DIFF_W-bpc_pkg::P_FINAL_SHIFT){1'b0}},
           {bpc_pkg::P_FINAL_SHIFT{s8_diff[bpc_pkg::DIFF_W-1]}}}))
          >>> bpc_pkg::P_FINAL_SHIFT;
    p_w = p_q[bpc_pkg::PQ_W-1:0];
    if (p_w > bpc_pkg::PQ_W'(bpc_pkg::P_MAX)) begin
      p_sat = bpc_pkg::PRESS_W'(bpc_pkg::P_MAX);
    end else if (p_w < bpc_pkg::PQ_W'(bpc_pkg::P_MIN)) begin
      p_sat = bpc_pkg::PRESS_W'(bpc_pkg::P_MIN);
    end else begin
      p_sat = p_w[bpc_pkg::PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      s6_valid  <= valid_in;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      valid_out <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pl             <= pl_next;
      s6_ph             <= ph_next;
      s6_off_f          <= data_in.off_f;
      s6_temp           <= data_in.temp_out;
      s7_prod           <= prod_next;
      s7_off_f          <= s6_off_f;
      s7_temp           <= s6_temp;
      s8_diff           <= diff_next;
      s8_temp           <= s7_temp;
      pressure_pa       <= p_sat;
      temperature_centi <= $signed(s8_temp);
    end
  end

endmodule

@@ rtl/baro_pressure_temp_compensation.sv @@
// Top level of the barometric compensation block: calibration registers,
// pipeline control and the three datapath sections. Depends on bpc_pkg,
// bpc_scale, bpc_corr and bpc_press.
//
// Accepts one raw pressure/temperature pair per clock while in_stall is low and
// returns compensated pressure (Pa, saturated) and temperature (0.01 C), one
// result per pair, in order. The datapath is a nine-stage pipeline that moves
// as one: while a result sits in the output register with out_stall high,
// every stage holds and in_stall is raised; otherwise a pair is taken every
// cycle. Calibration words are written through cfg_write/cfg_index/cfg_data
// and must only change while no pair is in flight.
module baro_pressure_temp_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bpc_pkg::IN_W-1:0]            raw_pressure,
  input  logic [bpc_pkg::IN_W-1:0]            raw_temperature,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bpc_pkg::PRESS_W-1:0]  pressure_pa,
  output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_centi,
  input  logic                                cfg_write,
  input  logic [bpc_pkg::IDX_W-1:0]           cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]           cfg_data
);

  bpc_pkg::cal_t   cal;
  bpc_pkg::scale_t scale_data;
  bpc_pkg::corr_t  corr_data;
  logic            scale_valid;
  logic            corr_valid;
  logic            en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bpc_pkg::REG_PRESSURE_SENSITIVITY:   cal.pressure_sensitivity   <= cfg_data;
        bpc_pkg::REG_PRESSURE_OFFSET:        cal.pressure_offset        <= cfg_data;
        bpc_pkg::REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff <= cfg_data;
        bpc_pkg::REG_OFFSET_TEMP_COEFF:      cal.offset_temp_coeff      <= cfg_data;
        bpc_pkg::REG_REFERENCE_TEMPERATURE:  cal.reference_temperature  <= cfg_data;
        bpc_pkg::REG_TEMPERATURE_SLOPE:      cal.temperature_slope      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bpc_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .valid_in        (in_valid),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .cal             (cal),
    .valid_out       (scale_valid),
    .data_out        (scale_data)
  );

  bpc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (scale_valid),
    .data_in   (scale_data),
    .valid_out (corr_valid),
    .data_out  (corr_data)
  );

  bpc_press u_press (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .valid_in          (corr_valid),
    .data_in           (corr_data),
    .valid_out         (out_valid),
    .pressure_pa       (pressure_pa),
    .temperature_centi (temperature_centi)
  );

`ifndef ASSERT_OFF
  a_freeze_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({scale_valid, corr_valid, out_valid}))
    else $error("pipeline valid bits moved while stalled");

  a_scale_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 en ##1 en |=> scale_valid)
    else $error("accepted transfer did not reach the scaling stage output");

  a_corr_follows: assert property (@(posedge clk) disable iff (rst)
    (scale_valid && en) ##1 en |=> corr_valid)
    else $error("scaled transfer did not reach the correction stage output");
`endif

endmodule
